// ----- rtl/iet_pkg.sv -----
`default_nettype none

package iet_pkg;

   // table geometry
   localparam int TABLE_DEPTH_DEF = 16;
   localparam int MAX_RESULTS     = 16;
   localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);

   // field widths
   localparam int MODE_W   = 2;
   localparam int ID_W     = 32;
   localparam int TIME_W   = 64;
   localparam int IMP_W    = 18;
   localparam int WEIGHT_W = 17;
   localparam int POS_W    = 4;
   localparam int CAP_W    = 5;

   localparam logic [CAP_W-1:0]    CAP_RESET   = 5'd16;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ZERO = 17'h00000;   // 0.0
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 17'h10000;   // 1.0

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_FIND   = 2'd1,
      MODE_RANGE  = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   // one table entry as held in a cell
   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [TIME_W-1:0]   stamp;
      logic [WEIGHT_W-1:0] weight;
   } entry_type;

   // per-cell controls from the sequencer
   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

   // per-cell compare results
   typedef struct packed {
      logic id_hit;
      logic in_range;
   } cell_flags_type;

   // signed Q2.16 importance to unsigned Q1.16, clamped to 0..1
   function automatic logic [WEIGHT_W-1:0] clamp_weight(input logic [IMP_W-1:0] raw);
      logic [WEIGHT_W-1:0] res;
      if (raw[IMP_W-1]) begin
         res = WEIGHT_ZERO;
      end else if (raw > {1'b0, WEIGHT_ONE}) begin
         res = WEIGHT_ONE;
      end else begin
         res = raw[WEIGHT_W-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/iet_req_if.sv -----
`default_nettype none

interface iet_req_if import iet_pkg::*;;
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [TIME_W-1:0]   event_time;
   logic [TIME_W-1:0]   range_end;
   logic [IMP_W-1:0]    importance_in;
   logic [ID_W-1:0]     query_id;

   modport source (output valid, mode, event_time, range_end, importance_in, query_id,
                   input ready);
   modport sink   (input valid, mode, event_time, range_end, importance_in, query_id,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/iet_rsp_if.sv -----
`default_nettype none

interface iet_rsp_if import iet_pkg::*;;
   logic             valid;
   logic             ready;
   logic [ID_W-1:0]  result_id;
   logic [POS_W-1:0] position;
   logic             found;
   logic             evicted;
   logic             last;

   modport source (output valid, result_id, position, found, evicted, last, input ready);
   modport sink   (input valid, result_id, position, found, evicted, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/importance_evicting_event_table.sv -----
// Items are taken one at a time; the next word is accepted once the sequencer is idle again.
// Insert: result word registered in S_APPEND once the output slot is free; eviction adds a minimum scan first.
// Find: one cell examined per cycle, newest hit kept; result word registered once the output slot is free.
// Range query: one cell per cycle, matches out one per cycle; a match waits while the output slot is full.
// Clear: no result, idle the next cycle. Sustained rate is set by the cell scan pointer.
// Reset: count and id counter cleared, capacity 16, output empty; cell contents not cleared.
`default_nettype none

module importance_evicting_event_table import iet_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_enable,
   input  wire logic [CAP_W-1:0] csr_write_data,
   iet_req_if.sink               req_ch,
   iet_rsp_if.source             rsp_ch
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int LW = (CW > CAP_W) ? CW : CAP_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MIN,
      S_APPEND,
      S_FIND,
      S_RANGE
   } state_type;

   state_type                state_ff;
   logic [CAP_W-1:0]         cap_ff;
   logic [CW-1:0]            count_ff;
   logic [ID_W-1:0]          next_id_ff;
   logic [CW-1:0]            ptr_ff;
   logic [TIME_W-1:0]        t0_ff;
   logic [TIME_W-1:0]        t1_ff;
   logic [ID_W-1:0]          qid_ff;
   logic [WEIGHT_W-1:0]      weight_ff;
   logic [WEIGHT_W-1:0]      min_ff;
   logic [IW-1:0]            midx_ff;
   logic                     evict_ff;
   logic                     hit_ff;
   logic [IW-1:0]            hpos_ff;
   logic                     held_vld_ff;
   logic [ID_W-1:0]          held_id_ff;
   logic [IW-1:0]            held_pos_ff;
   logic [RES_CNT_W-1:0]     k_ff;
   logic                     rsp_valid_ff;
   logic [ID_W-1:0]          rsp_id_ff;
   logic [POS_W-1:0]         rsp_pos_ff;
   logic                     rsp_found_ff;
   logic                     rsp_evicted_ff;
   logic                     rsp_last_ff;

   entry_type                cell_entry [TABLE_DEPTH];
   cell_flags_type           cell_flags [TABLE_DEPTH];
   cell_ctrl_type            cell_ctrl  [TABLE_DEPTH];
   entry_type                new_entry;
   entry_type                rd_entry;
   cell_flags_type           rd_flags;
   logic [IW-1:0]            ptr_idx;
   logic                     scan_live;
   logic                     range_live;
   logic                     slot_free;
   logic                     rsp_push;
   logic [LW-1:0]            cap_ext;
   logic [LW-1:0]            limit;
   logic                     must_evict;

   function automatic logic [POS_W-1:0] pos_bits(input logic [IW-1:0] idx);
      logic [POS_W+IW-1:0] wide;
      wide = {{POS_W{1'b0}}, idx};
      return wide[POS_W-1:0];
   endfunction

   // effective capacity: 0 acts as 1, above the depth acts as the depth
   always_comb begin
      cap_ext = LW'(cap_ff);
      if (cap_ext == '0) begin
         limit = LW'(1);
      end else if (cap_ext > LW'(TABLE_DEPTH)) begin
         limit = LW'(TABLE_DEPTH);
      end else begin
         limit = cap_ext;
      end
      must_evict = (LW'(count_ff) >= limit) && (count_ff != '0);
   end

   // scan pointer read of the cell row
   assign ptr_idx    = ptr_ff[IW-1:0];
   assign scan_live  = (ptr_ff < count_ff);
   assign range_live = scan_live && (k_ff < RES_CNT_W'(MAX_RESULTS));
   assign rd_entry   = cell_entry[ptr_idx];
   assign rd_flags   = cell_flags[ptr_idx];
   assign slot_free  = !rsp_valid_ff || rsp_ch.ready;
   assign new_entry  = '{id: next_id_ff, stamp: t0_ff, weight: weight_ff};

   // a result word enters the output register this cycle
   always_comb begin
      unique case (state_ff)
         S_APPEND: rsp_push = slot_free;
         S_FIND:   rsp_push = !scan_live && slot_free;
         S_RANGE:  rsp_push = slot_free && (!range_live || (rd_flags.in_range && held_vld_ff));
         default:  rsp_push = 1'b0;
      endcase
   end

   // row of cells; each closes up from its right-hand neighbour
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      always_comb begin
         cell_ctrl[i].shift = (state_ff == S_MIN) && !scan_live
                              && (IW'(i) >= midx_ff) && (CW'(i + 1) < count_ff);
         cell_ctrl[i].load  = (state_ff == S_APPEND) && slot_free && (count_ff == CW'(i));
      end

      iet_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl[i]),
         .new_entry   (new_entry),
         .right_entry (cell_entry[(i + 1 < TABLE_DEPTH) ? i + 1 : i]),
         .query_id    (qid_ff),
         .range_lo    (t0_ff),
         .range_hi    (t1_ff),
         .entry       (cell_entry[i]),
         .flags       (cell_flags[i])
      );
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         next_id_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         held_vld_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
         if (rsp_push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  t0_ff     <= req_ch.event_time;
                  t1_ff     <= req_ch.range_end;
                  qid_ff    <= req_ch.query_id;
                  weight_ff <= clamp_weight(req_ch.importance_in);
                  unique case (mode_type'(req_ch.mode))
                     MODE_INSERT: begin
                        evict_ff <= must_evict;
                        min_ff   <= cell_entry[0].weight;
                        midx_ff  <= '0;
                        ptr_ff   <= CW'(1);
                        state_ff <= must_evict ? S_MIN : S_APPEND;
                     end
                     MODE_FIND: begin
                        hit_ff   <= 1'b0;
                        hpos_ff  <= '0;
                        ptr_ff   <= '0;
                        state_ff <= S_FIND;
                     end
                     MODE_RANGE: begin
                        k_ff        <= '0;
                        held_vld_ff <= 1'b0;
                        ptr_ff      <= '0;
                        state_ff    <= S_RANGE;
                     end
                     MODE_CLEAR: begin
                        count_ff   <= '0;
                        next_id_ff <= '0;
                     end
                     default: ;
                  endcase
               end
            end

            // first lowest importance wins; strict compare keeps the earlier one
            S_MIN: begin
               if (scan_live) begin
                  if (rd_entry.weight < min_ff) begin
                     min_ff  <= rd_entry.weight;
                     midx_ff <= ptr_idx;
                  end
                  ptr_ff <= ptr_ff + CW'(1);
               end else begin
                  count_ff <= count_ff - CW'(1);
                  state_ff <= S_APPEND;
               end
            end

            S_APPEND: begin
               if (slot_free) begin
                  rsp_id_ff      <= next_id_ff;
                  rsp_pos_ff     <= pos_bits(count_ff[IW-1:0]);
                  rsp_found_ff   <= 1'b1;
                  rsp_evicted_ff <= evict_ff;
                  rsp_last_ff    <= 1'b1;
                  count_ff       <= count_ff + CW'(1);
                  next_id_ff     <= next_id_ff + ID_W'(1);
                  state_ff       <= S_IDLE;
               end
            end

            // newest hit is the one at the highest position
            S_FIND: begin
               if (scan_live) begin
                  if (rd_flags.id_hit) begin
                     hit_ff  <= 1'b1;
                     hpos_ff <= ptr_idx;
                  end
                  ptr_ff <= ptr_ff + CW'(1);
               end else if (slot_free) begin
                  rsp_id_ff      <= qid_ff;
                  rsp_pos_ff     <= pos_bits(hpos_ff);
                  rsp_found_ff   <= hit_ff;
                  rsp_evicted_ff <= 1'b0;
                  rsp_last_ff    <= 1'b1;
                  state_ff       <= S_IDLE;
               end
            end

            // one match held back so the final word can carry last
            S_RANGE: begin
               if (range_live) begin
                  if (!rd_flags.in_range) begin
                     ptr_ff <= ptr_ff + CW'(1);
                  end else if (!held_vld_ff || slot_free) begin
                     if (held_vld_ff) begin
                        rsp_id_ff      <= held_id_ff;
                        rsp_pos_ff     <= pos_bits(held_pos_ff);
                        rsp_found_ff   <= 1'b1;
                        rsp_evicted_ff <= 1'b0;
                        rsp_last_ff    <= 1'b0;
                     end
                     held_vld_ff <= 1'b1;
                     held_id_ff  <= rd_entry.id;
                     held_pos_ff <= ptr_idx;
                     k_ff        <= k_ff + RES_CNT_W'(1);
                     ptr_ff      <= ptr_ff + CW'(1);
                  end
               end else if (slot_free) begin
                  rsp_id_ff      <= held_vld_ff ? held_id_ff : '0;
                  rsp_pos_ff     <= held_vld_ff ? pos_bits(held_pos_ff) : '0;
                  rsp_found_ff   <= held_vld_ff;
                  rsp_evicted_ff <= 1'b0;
                  rsp_last_ff    <= 1'b1;
                  held_vld_ff    <= 1'b0;
                  state_ff       <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ch.ready     = (state_ff == S_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.result_id = rsp_id_ff;
   assign rsp_ch.position  = rsp_pos_ff;
   assign rsp_ch.found     = rsp_found_ff;
   assign rsp_ch.evicted   = rsp_evicted_ff;
   assign rsp_ch.last      = rsp_last_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && (req_ch.mode == MODE_CLEAR)
      |=> (count_ff == '0) && (next_id_ff == '0))
      else $error("clear did not empty the table");

   a_evict_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_evicted_ff |-> rsp_found_ff && rsp_last_ff)
      else $error("eviction flagged on a non-insert word");

   a_miss_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_last_ff)
      else $error("not-found word without last");

   a_min_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MIN) |-> (count_ff != '0))
      else $error("minimum scan on an empty table");

endmodule

`default_nettype wire

// ----- rtl/iet_cell.sv -----
`default_nettype none

module iet_cell import iet_pkg::*; (
   input  wire logic              clock,
   input  wire cell_ctrl_type     ctrl,
   input  wire entry_type         new_entry,
   input  wire entry_type         right_entry,
   input  wire logic [ID_W-1:0]   query_id,
   input  wire logic [TIME_W-1:0] range_lo,
   input  wire logic [TIME_W-1:0] range_hi,
   output entry_type              entry,
   output cell_flags_type         flags
);

   entry_type entry_ff;
   entry_type entry_in;

   // load a new entry, or close up from the right-hand neighbour
   always_comb begin
      if (ctrl.load) begin
         entry_in = new_entry;
      end else if (ctrl.shift) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // local compares against the broadcast query
   always_comb begin
      flags.id_hit   = (entry_ff.id == query_id);
      flags.in_range = (entry_ff.stamp >= range_lo) && (entry_ff.stamp <= range_hi);
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire
